>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    // command codes of an input transaction
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2
    } t_spq_cmd;

    // status codes of a result transaction
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_spq_status;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD     = 2'd0,
        OP_INSERT   = 2'd1,
        OP_SHIFT_UP = 2'd2
    } t_spq_op;

    typedef struct packed {
        t_spq_cmd                   command;
        logic signed [VALUE_W-1:0]  value;
    } t_spq_in;

    typedef struct packed {
        t_spq_status                status;
        logic signed [VALUE_W-1:0]  top_value;
        logic                       top_valid;
        logic [COUNT_W-1:0]         count;
    } t_spq_out;

    // control broadcast from the top level to the cell chain
    typedef struct packed {
        t_spq_op                    op;
        logic signed [VALUE_W-1:0]  value;
    } t_spq_cell_ctrl;

endpackage

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One entry of the sorted chain: holds a value and takes its own, the new
// value, or a neighbor's value depending on the broadcast operation.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                       i_clk,
    input  t_spq_cell_ctrl             i_ctrl,
    input  logic                       i_occ,
    input  logic                       i_left_gt,
    input  logic signed [VALUE_W-1:0]  i_left_val,
    input  logic signed [VALUE_W-1:0]  i_right_val,
    output logic                       o_gt,
    output logic signed [VALUE_W-1:0]  o_val,
    output logic signed [VALUE_W-1:0]  o_nxt
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    // stored entry strictly greater than the new value stays in place
    assign o_gt = i_occ && (r_val > i_ctrl.value);

    // next entry value
    always_comb begin
        unique case (i_ctrl.op)
            OP_INSERT: begin
                if (o_gt) begin
                    n_val = r_val;
                end else if (i_left_gt) begin
                    n_val = i_ctrl.value;
                end else begin
                    n_val = i_left_val;
                end
            end
            OP_SHIFT_UP: n_val = i_right_val;
            OP_HOLD:     n_val = r_val;
            default:     n_val = r_val;
        endcase
    end

    // entry register
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_nxt = n_val;

endmodule

>>> design/sorted_priority_queue.sv
// A result is registered and appears in the cycle after its command is accepted.
// Throughput: one command per cycle while the receiver does not stall; all cells insert or shift in parallel.
// A command is accepted while the previous result is being taken.
// Reset (synchronous, active low) empties the queue, sets capacity to 16
// and drops any pending result; stored entry values are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Max-priority queue held as a descending chain of cells with insert,
// remove-max and peek commands.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_spq_in           i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_spq_out          o_out,
    input  logic              i_cfg_wr_en,
    input  logic [CAP_W-1:0]  i_cfg_wr_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CAP_W-1:0]          r_cap;
    logic                      r_out_valid;
    t_spq_out                  r_out;
    t_spq_out                  n_out;
    logic                      accept;
    logic                      full;
    logic                      empty;
    t_spq_status               status;
    t_spq_cell_ctrl            ctrl;

    logic signed [VALUE_W-1:0] vals [DEPTH];
    logic signed [VALUE_W-1:0] nxts [DEPTH];
    logic                      gts  [DEPTH];

    // input transaction handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // queue status
    assign full  = (r_count >= CW'(DEPTH)) || (CMPW'(r_count) >= CMPW'(r_cap));
    assign empty = (r_count == '0);

    // decode command into cell operation and new count
    always_comb begin
        status     = ST_DONE;
        ctrl.op    = OP_HOLD;
        ctrl.value = i_in.value;
        n_count    = r_count;
        unique case (i_in.command)
            CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op = accept ? OP_INSERT : OP_HOLD;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctrl.op = accept ? OP_SHIFT_UP : OP_HOLD;
                    n_count = r_count - CW'(1);
                end
            end
            default: status = ST_DONE;
        endcase
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                      occ;
        logic                      left_gt;
        logic signed [VALUE_W-1:0] left_val;
        logic signed [VALUE_W-1:0] right_val;

        assign occ = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_gt  = 1'b1;
            assign left_val = '0;
        end else begin : g_body
            assign left_gt  = gts[g-1];
            assign left_val = vals[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = vals[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_occ       (occ),
            .i_left_gt   (left_gt),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_gt        (gts[g]),
            .o_val       (vals[g]),
            .o_nxt       (nxts[g])
        );
    end

    // result of the accepted transaction
    always_comb begin
        n_out.status    = status;
        n_out.top_valid = (n_count != '0);
        n_out.top_value = (n_count != '0) ? nxts[0] : '0;
        n_out.count     = COUNT_W'(n_count);
    end

    // count and capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_W'(16);
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // count never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // a completed insert grows the queue by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command == CMD_INSERT && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the queue");

    // pending result agrees with the stored count
    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.top_valid == (r_count != '0)))
        else $error("top valid disagrees with count");

    // head of the chain is the maximum
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (vals[0] >= vals[1]))
        else $error("chain head out of order");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue: drives insert, remove
// and peek commands plus capacity writes, predicts every result with a
// sorted-array model of the queue and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 16;
    localparam int PHASE_ITEMS    = 100;

    // unused command encoding, behaves as a peek
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    // expected-result tracker: mirrors the queue contents and capacity
    class spq_scoreboard;
        logic signed [VALUE_W-1:0] entries [QUEUE_DEPTH];
        int unsigned               n_stored;
        logic [CAP_W-1:0]          cap_reg;
        t_spq_out                  result_q[$];
        int unsigned               errors;

        function new();
            n_stored = 0;
            cap_reg  = 5'd16;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            cap_reg = cap;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        // apply one accepted command and queue the result it must produce
        function void note_command(t_spq_in item);
            t_spq_out    res;
            int unsigned limit;
            int unsigned pos;
            int unsigned k;
            res.status = ST_DONE;
            case (item.command)
                CMD_INSERT: begin
                    limit = (cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg;
                    if (n_stored >= limit) begin
                        res.status = ST_FULL;
                    end else begin
                        // new value goes after every strictly greater entry
                        pos = 0;
                        while (pos < n_stored &&
                               $signed(entries[pos]) > $signed(item.value))
                            pos++;
                        for (k = n_stored; k > pos; k--)
                            entries[k] = entries[k-1];
                        entries[pos] = item.value;
                        n_stored++;
                    end
                end
                CMD_REMOVE: begin
                    if (n_stored == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        for (k = 0; k + 1 < n_stored; k++)
                            entries[k] = entries[k+1];
                        n_stored--;
                    end
                end
                default: ;
            endcase
            res.top_valid = (n_stored != 0);
            res.top_value = (n_stored != 0) ? entries[0] : '0;
            res.count     = COUNT_W'(n_stored);
            result_q.push_back(res);
        endfunction

        // compare one accepted result with the oldest expected one
        function void check_result(t_spq_out got);
            t_spq_out want;
            if (result_q.size() == 0) begin
                $error("unexpected result transaction: status %0d count %0d",
                       got.status, got.count);
                errors++;
                return;
            end
            want = result_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.top_value !== want.top_value) begin
                $error("top_value: expected %0d, actual %0d",
                       $signed(want.top_value), $signed(got.top_value));
                errors++;
            end
            if (got.top_valid !== want.top_valid) begin
                $error("top_valid: expected %0d, actual %0d",
                       want.top_valid, got.top_valid);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    t_spq_in           in_data = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    t_spq_out          o_out;
    logic              cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;

    logic              idle_on = 1'b1;
    logic              hold_req = 1'b0;
    int unsigned       quiet_cycles = 0;

    spq_scoreboard     sb = new();

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_result(o_out);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one command, with an optional idle burst first; returns at a negedge
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] val);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: t_spq_cmd'(cmd), value: val};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(in_data);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(cap);
    endtask

    // values lean on the extremes and on small numbers so equal keys occur
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $signed(VALUE_W'($urandom_range(0, 8))) - 4;
            3:       return $signed(VALUE_W'($urandom_range(0, 15)));
            default: return $signed(VALUE_W'($urandom()));
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int unsigned insert_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return CMD_INSERT;
        r = $urandom_range(0, 19);
        if (r < 14)
            return CMD_REMOVE;
        if (r < 18)
            return CMD_PEEK;
        return CMD_SPARE;
    endfunction

    // capacity per phase: extremes first, then random over the whole field
    function automatic logic [CAP_W-1:0] pick_capacity(int ph);
        case (ph)
            0:       return 5'd16;
            1:       return 5'd31;
            2:       return 5'd1;
            3:       return 5'd0;
            4:       return 5'd2;
            5:       return 5'd17;
            6:       return 5'd8;
            default: return CAP_W'($urandom_range(0, 31));
        endcase
    endfunction

    // main sequence
    initial begin
        int unsigned insert_pct;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty queue, extremes, equal keys, spare command
        send_command(CMD_PEEK, 32'sd0);
        send_command(CMD_REMOVE, 32'sh0000_1234);
        send_command(CMD_SPARE, 32'sd7);
        send_command(CMD_INSERT, VAL_MAX);
        send_command(CMD_INSERT, VAL_MIN);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_PEEK, -32'sd1);
        repeat (5) send_command(CMD_REMOVE, $signed(VALUE_W'($urandom())));
        send_command(CMD_REMOVE, 32'sd0);

        // directed: zero capacity refuses inserts, capacity of one
        write_capacity(5'd0);
        send_command(CMD_INSERT, 32'sd5);
        send_command(CMD_PEEK, 32'sd0);
        write_capacity(5'd1);
        send_command(CMD_INSERT, -32'sd7);
        send_command(CMD_INSERT, 32'sd9);
        send_command(CMD_REMOVE, 32'sd0);

        // random phases; capacity changes keep the stored entries
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(pick_capacity(ph));
            case ($urandom_range(0, 2))
                0:       insert_pct = 75;
                1:       insert_pct = 50;
                default: insert_pct = 25;
            endcase
            if (ph == 1)
                insert_pct = 90;
            // no idling in the final phases and in one middle phase
            idle_on = (ph < NUM_PHASES - 2) && (ph != 7);
            // long receiver hold while commands keep coming
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_command(pick_command(insert_pct), pick_value());
            end
        end

        // wait out every expected result plus the block latency
        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
